[rtl/fwip_pkg.sv]
// ----------------------------------------------------------------------------
// fwip_pkg
// Shared types and constants of the fixed-width integer field parser.
// ----------------------------------------------------------------------------
package fwip_pkg;

  localparam int unsigned ColsDefault = 10;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned CharW       = 8;

  typedef struct packed {
    logic             kind;
    logic [CharW-1:0] char_byte;
  } item_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     error;
  } result_t;

  localparam logic KindChar = 1'b0;
  localparam logic KindEnd  = 1'b1;

endpackage

[rtl/fwip_in_reg.sv]
// ----------------------------------------------------------------------------
// fwip_in_reg
// Input register: holds one word until the parser core takes it.
// ----------------------------------------------------------------------------
module fwip_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fwip_pkg::item_t item_i,
  input  logic           take_i,
  output logic           valid_o,
  output fwip_pkg::item_t item_o
);

  logic            valid_q;
  fwip_pkg::item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

[rtl/fwip_core.sv]
// ----------------------------------------------------------------------------
// fwip_core
// Parser state: per-character phase update and digit accumulation; an end
// word yields the result and clears the state.
// ----------------------------------------------------------------------------
module fwip_core #(
  parameter int unsigned COLS = fwip_pkg::ColsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  fwip_pkg::item_t   item_i,
  input  logic              out_space_i,
  output logic              take_o,
  output logic              res_valid_o,
  output fwip_pkg::result_t res_o
);

  localparam int unsigned CntW = $clog2(COLS + 1);
  localparam int unsigned MagW = fwip_pkg::ValueW + 1;
  localparam int unsigned MulW = MagW + 4;

  localparam logic [fwip_pkg::CharW-1:0] ChSpace = 8'd32;
  localparam logic [fwip_pkg::CharW-1:0] ChPlus  = 8'd43;
  localparam logic [fwip_pkg::CharW-1:0] ChMinus = 8'd45;
  localparam logic [fwip_pkg::CharW-1:0] ChZero  = 8'd48;
  localparam logic [fwip_pkg::CharW-1:0] ChNine  = 8'd57;
  localparam logic [fwip_pkg::CharW-1:0] ChTab   = 8'd9;
  localparam logic [fwip_pkg::CharW-1:0] ChCr    = 8'd13;

  localparam logic [MagW-1:0] MagCap  = {1'b1, {(MagW-1){1'b0}}};
  localparam logic [MagW-1:0] NegMax  = MagW'(64'h8000_0000);
  localparam logic [MagW-1:0] PosMax  = MagW'(64'h7FFF_FFFF);

  typedef enum logic [2:0] {
    PhLead, PhWs, PhSign, PhDigits, PhTrail, PhBad
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [MagW-1:0] mag_q, mag_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            nonspace_q, nonspace_d;
  logic            ended_q, ended_d;

  logic [fwip_pkg::CharW-1:0] c;
  logic            is_digit, is_ws, fire;
  logic [3:0]      digit;
  logic [MulW-1:0] acc;
  logic            blank, ok;
  logic [fwip_pkg::ValueW-1:0] mag_lo;

  assign c        = item_i.char_byte;
  assign is_digit = (c >= ChZero) && (c <= ChNine);
  assign is_ws    = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  assign digit    = 4'(c - ChZero);
  assign acc      = (MulW'(mag_q) << 3) + (MulW'(mag_q) << 1) + MulW'(digit);

  assign take_o = valid_i && ((item_i.kind == fwip_pkg::KindChar) || out_space_i);
  assign fire   = take_o;

  always_comb begin
    phase_d    = phase_q;
    mag_d      = mag_q;
    neg_d      = neg_q;
    cnt_d      = cnt_q;
    nonspace_d = nonspace_q;
    ended_d    = ended_q;
    if (fire && (item_i.kind == fwip_pkg::KindEnd)) begin
      phase_d    = PhLead;
      mag_d      = '0;
      neg_d      = 1'b0;
      cnt_d      = '0;
      nonspace_d = 1'b0;
      ended_d    = 1'b0;
    end else if (fire && !ended_q && (cnt_q < CntW'(COLS))) begin
      cnt_d = cnt_q + 1'b1;
      if (c == '0) begin
        ended_d = 1'b1;
      end else begin
        if (c != ChSpace) begin
          nonspace_d = 1'b1;
        end
        unique case (phase_q)
          PhLead, PhWs: begin
            if (c == ChSpace) begin
              phase_d = phase_q;
            end else if (is_ws) begin
              phase_d = PhWs;
            end else if ((c == ChPlus) || (c == ChMinus)) begin
              neg_d   = (c == ChMinus);
              phase_d = PhSign;
            end else if (is_digit) begin
              mag_d   = MagW'(digit);
              phase_d = PhDigits;
            end else begin
              phase_d = PhBad;
            end
          end
          PhSign: begin
            if (is_digit) begin
              mag_d   = MagW'(digit);
              phase_d = PhDigits;
            end else begin
              phase_d = PhBad;
            end
          end
          PhDigits: begin
            if (is_digit) begin
              mag_d = (acc > MulW'(MagCap)) ? MagCap : acc[MagW-1:0];
            end else if (c == ChSpace) begin
              phase_d = PhTrail;
            end else begin
              phase_d = PhBad;
            end
          end
          PhTrail: begin
            if (c != ChSpace) begin
              phase_d = PhBad;
            end
          end
          default: phase_d = PhBad;
        endcase
      end
    end
  end

  // end-of-field result
  assign blank  = (phase_q == PhLead) && !nonspace_q;
  assign mag_lo = mag_q[fwip_pkg::ValueW-1:0];
  assign ok     = ((phase_q == PhDigits) || (phase_q == PhTrail)) &&
                  (neg_q ? (mag_q <= NegMax) : (mag_q <= PosMax));

  always_comb begin
    res_valid_o = fire && (item_i.kind == fwip_pkg::KindEnd);
    res_o.error = !blank && !ok;
    if (!blank && ok) begin
      res_o.value = neg_q ? $signed(-mag_lo) : $signed(mag_lo);
    end else begin
      res_o.value = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhLead;
      mag_q      <= '0;
      neg_q      <= 1'b0;
      cnt_q      <= '0;
      nonspace_q <= 1'b0;
      ended_q    <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      mag_q      <= mag_d;
      neg_q      <= neg_d;
      cnt_q      <= cnt_d;
      nonspace_q <= nonspace_d;
      ended_q    <= ended_d;
    end
  end

endmodule

[rtl/fwip_out_reg.sv]
// ----------------------------------------------------------------------------
// fwip_out_reg
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module fwip_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  fwip_pkg::result_t res_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fwip_pkg::result_t res_o
);

  logic              valid_q;
  fwip_pkg::result_t res_q;

  assign space_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && space_o) begin
      res_q <= res_i;
    end
  end

endmodule

[rtl/fixed_width_int_field_parser.sv]
// ----------------------------------------------------------------------------
// fixed_width_int_field_parser
// Parses a fixed-width ASCII decimal field into a signed 32-bit integer.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o): one word per cycle, either a field
// character (kind_i = 0, char_byte_i) or an end-of-field marker (kind_i = 1).
// Only the first COLS characters count; a zero byte ends the text early.
// Output channel (out_valid_o / out_ready_i): one result word per end marker,
// value_o and error_o. Blank fields give 0 without error; malformed fields or
// values outside int32 give 0 with error_o set.
// Timing: a word is registered in the input register and processed by the
// parser core from there; an end marker's result is loaded into the output
// register when the core takes the marker.
// Throughput: one word per cycle while no end marker waits for the output
// register; the multiply-by-ten and add in the core are combinational.
// Reset clears the parser state and both valid registers; no result is
// pending afterwards. When the receiver stalls, character words keep flowing
// through the core; an end marker waits in the input register until the
// output register frees, and in_ready_o drops only then.
// ----------------------------------------------------------------------------
module fixed_width_int_field_parser #(
  parameter int unsigned COLS = fwip_pkg::ColsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                kind_i,
  input  logic [fwip_pkg::CharW-1:0]          char_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [fwip_pkg::ValueW-1:0]  value_o,
  output logic                                error_o
);

  fwip_pkg::item_t   in_item, s1_item;
  fwip_pkg::result_t core_res, out_res;
  logic              s1_valid, take, res_valid, out_space;

  assign in_item.kind      = kind_i;
  assign in_item.char_byte = char_byte_i;

  fwip_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .take_i     (take),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  fwip_core #(
    .COLS (COLS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .item_i      (s1_item),
    .out_space_i (out_space),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (core_res)
  );

  fwip_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (core_res),
    .space_o     (out_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign value_o = out_res.value;
  assign error_o = out_res.error;

endmodule
